// ----- rtl/tdt_pkg.sv -----
// Shared types and constants for the table-driven DFA tokenizer.
// Holds table sizes, command codes, sequencer states and the result record.
// No dependencies.
package tdt_pkg;

  localparam int NUM_STATES       = 256;
  localparam int NUM_CLASSES      = 64;
  localparam int NEXT_TABLE_DEPTH = 4096;
  localparam int CLASS_DEPTH      = 256;

  localparam int ST_AW  = $clog2(NUM_STATES);
  localparam int NT_AW  = $clog2(NEXT_TABLE_DEPTH);
  localparam int CLS_AW = $clog2(CLASS_DEPTH);
  localparam int CLS_W  = $clog2(NUM_CLASSES);

  localparam int STATE_W = 8;
  localparam int BASE_W  = 12;
  localparam int TERM_W  = 11;
  localparam int SUM_W   = BASE_W + 1;

  localparam logic [TERM_W-1:0] TERM_WS  = '1;
  localparam logic [19:0]       LINE_MAX = 20'hFFFFF;
  localparam logic [15:0]       COL_MAX  = 16'hFFFF;
  localparam logic [7:0]        CH_NL    = 8'h0A;
  localparam logic [7:0]        CH_TAB   = 8'h09;
  localparam logic [3:0]        TAB_RST  = 4'd3;

  localparam logic CFG_TAB_WIDTH  = 1'b0;
  localparam logic CFG_SEVEN_BIT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_CHAR  = 3'd0,
    CMD_CLASS = 3'd1,
    CMD_BASE  = 3'd2,
    CMD_NEXT  = 3'd3,
    CMD_TERM  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TMOD,
    S_ADDR,
    S_EVAL,
    S_RADDR,
    S_OUT1,
    S_OUT2
  } fsm_e;

  // terminal in the lowest bits
  typedef struct packed {
    logic [15:0] token_on_line;
    logic [15:0] token_length;
    logic [15:0] token_column;
    logic [19:0] token_line;
    logic [9:0]  terminal;
  } res_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == COL_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ----- rtl/tdt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module tdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/table_driven_dfa_tokenizer.sv -----
// Table-driven DFA tokenizer top level: sequencer, position counters and output register.
// Depends on tdt_pkg and four tdt_ram instances for the lexer tables.
//
// Input stream: s_axis_tuser carries the command, s_axis_tdata the table index,
// table value and character. Commands 1..4 write an in-range table entry in the cycle they
// are accepted and produce nothing. Command 0 runs one character through the DFA.
// Output stream: one transaction per token, m_axis_tlast on the final token
// caused by a character. A character yields zero, one or two tokens.
// Sequence: a character is read through the chain class/row base read -> next state
// read -> decide, and the block is not ready for the next item until it is done; a token
// end repeats the chain from state zero for the same character. A tab first
// computes the column remainder, 4 bits per cycle. A table write leaves the block
// ready. Results leave through an output register, so a stalled receiver holds the
// block only when a new token must be loaded.
// Reset: DFA state 0, line 1, column 0, tab width 3, 7-bit mode off. Table
// contents are undefined until written; no clearing pass is made.
// Configuration: cfg_index_i 0 is tab width, 1 is 7-bit mode; write only while idle.
module table_driven_dfa_tokenizer
  import tdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] table_index, [24:12] table_value, [32:25] ch, [39:33] zero
  input  logic [39:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] terminal, [29:10] token_line, [45:30] token_column,
  // [61:46] token_length, [77:62] token_on_line, [79:78] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  fsm_e state_q, state_d;

  logic [3:0]  tab_q;
  logic        sbo_q;
  logic [STATE_W-1:0] dfa_q, dfa_d;
  logic [19:0] line_q, line_d, sline_q, sline_d;
  logic [15:0] col_q, col_d, scol_q, scol_d, len_q, len_d, ltc_q, ltc_d;
  logic        hv_q, hv_d, err_q, err_d;
  logic        out_valid_q, out_valid_d, out_last_q, out_last_d;
  res_t        out_q, out_d, hold_q, hold_d, eres_q, eres_d;
  logic [7:0]  ch_q, ch_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic        oor_q, oor_d, st_oor_q, st_oor_d;
  logic [15:0] tshift_q, tshift_d;
  logic [3:0]  rem_q, rem_d;
  logic [1:0]  tcnt_q, tcnt_d;
  logic [4:0]  tstep_q, tstep_d;

  logic        acc, char_acc, retry_issue, out_free, out_load;
  cmd_e        cmd;
  logic [11:0] in_idx;
  logic [12:0] in_val;
  logic [7:0]  in_ch, cc;
  logic [3:0]  tw_eff;

  logic [CLS_W-1:0]   cls_rd;
  logic [BASE_W-1:0]  base_rd, base_eff;
  logic [STATE_W-1:0] next_rd, nx;
  logic [TERM_W-1:0]  term_rd;
  logic [SUM_W-1:0]   sum;
  logic [ST_AW-1:0]   st_raddr;
  logic               cls_we, base_we, next_we, term_we, st_re, next_re;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign in_idx = s_axis_tdata[11:0];
  assign in_val = s_axis_tdata[24:12];
  assign in_ch  = s_axis_tdata[32:25];

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign char_acc      = acc && (cmd == CMD_CHAR);
  assign cc            = (sbo_q && in_ch[7]) ? 8'd0 : in_ch;
  assign tw_eff        = (tab_q == 4'd0) ? 4'd1 : tab_q;

  assign cls_we  = acc && (cmd == CMD_CLASS) && (32'(in_idx) < CLASS_DEPTH);
  assign base_we = acc && (cmd == CMD_BASE) && (32'(in_idx) < NUM_STATES);
  assign next_we = acc && (cmd == CMD_NEXT) && (32'(in_idx) < NEXT_TABLE_DEPTH);
  assign term_we = acc && (cmd == CMD_TERM) && (32'(in_idx) < NUM_STATES);

  assign nx          = oor_q ? '0 : next_rd;
  assign retry_issue = (state_q == S_EVAL) && (nx == '0) && (dfa_q != '0);
  assign st_re       = char_acc || retry_issue;
  assign st_raddr    = (state_q == S_EVAL) ? '0 : ST_AW'(dfa_q);
  assign base_eff    = ((state_q == S_ADDR) && st_oor_q) ? '0 : base_rd;
  assign sum         = SUM_W'(base_eff) + SUM_W'(cls_rd);
  assign next_re     = (state_q == S_ADDR) || (state_q == S_RADDR);

  tdt_ram #(.Width(CLS_W), .Depth(CLASS_DEPTH)) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (CLS_AW'(in_idx)),
    .wdata_i (in_val[CLS_W-1:0]),
    .re_i    (char_acc),
    .raddr_i (cc),
    .rdata_o (cls_rd)
  );

  tdt_ram #(.Width(BASE_W), .Depth(NUM_STATES)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (ST_AW'(in_idx)),
    .wdata_i (in_val[BASE_W-1:0]),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (base_rd)
  );

  tdt_ram #(.Width(STATE_W), .Depth(NEXT_TABLE_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (NT_AW'(in_idx)),
    .wdata_i (in_val[STATE_W-1:0]),
    .re_i    (next_re),
    .raddr_i (NT_AW'(sum)),
    .rdata_o (next_rd)
  );

  tdt_ram #(.Width(TERM_W), .Depth(NUM_STATES)) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (ST_AW'(in_idx)),
    .wdata_i (in_val[TERM_W-1:0]),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (term_rd)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (char_acc) begin
          state_d = (in_ch == CH_TAB) ? S_TMOD : S_ADDR;
        end
      end
      S_TMOD: begin
        if (tcnt_q == 2'd3) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR:  state_d = S_EVAL;
      S_RADDR: state_d = S_EVAL;
      S_EVAL: begin
        state_d = retry_issue ? S_RADDR : S_OUT1;
      end
      S_OUT1: begin
        if (!hv_q || out_free) begin
          state_d = S_OUT2;
        end
      end
      S_OUT2: begin
        if (!err_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // tab remainder: column mod tab width, 4 bits per cycle
  always_comb begin
    logic [4:0] r5;
    logic [3:0] r;
    r = (state_q == S_TMOD) ? rem_q : 4'd0;
    r5 = '0;
    for (int i = 0; i < 4; i++) begin
      r5 = {r, tshift_q[15 - i]};
      if (r5 >= {1'b0, tw_eff}) begin
        r5 = r5 - {1'b0, tw_eff};
      end
      r = r5[3:0];
    end
    rem_d    = rem_q;
    tcnt_d   = tcnt_q;
    tshift_d = tshift_q;
    tstep_d  = tstep_q;
    if (char_acc) begin
      rem_d    = 4'd0;
      tcnt_d   = 2'd0;
      tshift_d = col_q;
    end else if (state_q == S_TMOD) begin
      rem_d    = r;
      tcnt_d   = tcnt_q + 2'd1;
      tshift_d = {tshift_q[11:0], 4'd0};
      tstep_d  = {1'b0, tw_eff} - {1'b0, r};
    end
  end

  // datapath
  always_comb begin
    logic [16:0] col_tab;
    logic [15:0] ltc_emit, ltc_base;
    logic        adv;
    col_tab  = 17'(col_q) + 17'(tstep_q);
    ltc_emit = sat16_inc(ltc_q);
    ltc_base = ltc_q;
    adv      = 1'b0;

    dfa_d    = dfa_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    len_d    = len_q;
    ltc_d    = ltc_q;
    hv_d     = hv_q;
    err_d    = err_q;
    hold_d   = hold_q;
    eres_d   = eres_q;
    ch_d     = ch_q;
    term_d   = term_q;
    oor_d    = oor_q;
    st_oor_d = st_oor_q;

    case (state_q)
      S_IDLE: begin
        if (char_acc) begin
          ch_d     = in_ch;
          hv_d     = 1'b0;
          err_d    = 1'b0;
          st_oor_d = (32'(dfa_q) >= NUM_STATES);
          if (dfa_q == '0) begin
            sline_d = line_q;
            scol_d  = sat16_inc(col_q);
            len_d   = '0;
          end
        end
      end
      S_ADDR, S_RADDR: begin
        oor_d  = (32'(sum) >= NEXT_TABLE_DEPTH);
        term_d = ((state_q == S_ADDR) && st_oor_q) ? '0 : term_rd;
      end
      S_EVAL: begin
        if (nx != '0) begin
          adv   = 1'b1;
          len_d = sat16_inc(len_q);
          dfa_d = nx;
        end else if (dfa_q != '0) begin
          if (term_q != TERM_WS) begin
            hold_d = '{token_on_line: ltc_emit, token_length: len_q, token_column: scol_q,
                       token_line: sline_q, terminal: term_q[9:0]};
            hv_d   = 1'b1;
            ltc_d  = ltc_emit;
          end
          dfa_d   = '0;
          sline_d = line_q;
          scol_d  = sat16_inc(col_q);
          len_d   = '0;
        end else begin
          eres_d = '{token_on_line: ltc_emit, token_length: 16'd1, token_column: scol_q,
                     token_line: sline_q,
                     terminal: (term_q == TERM_WS) ? 10'd0 : term_q[9:0]};
          err_d    = 1'b1;
          ltc_base = ltc_emit;
          ltc_d    = ltc_emit;
          adv      = 1'b1;
          dfa_d    = '0;
        end
        if (adv) begin
          if (ch_q == CH_NL) begin
            line_d = (line_q == LINE_MAX) ? line_q : line_q + 20'd1;
            col_d  = '0;
            ltc_d  = '0;
          end else if (ch_q == CH_TAB) begin
            col_d  = col_tab[16] ? COL_MAX : col_tab[15:0];
            ltc_d  = ltc_base;
          end else begin
            col_d  = sat16_inc(col_q);
            ltc_d  = ltc_base;
          end
        end
      end
      default: ;
    endcase
  end

  // output register load
  always_comb begin
    out_load   = 1'b0;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (state_q == S_OUT1 && hv_q && out_free) begin
      out_load   = 1'b1;
      out_d      = hold_q;
      out_last_d = !err_q;
    end else if (state_q == S_OUT2 && err_q && out_free) begin
      out_load   = 1'b1;
      out_d      = eres_q;
      out_last_d = 1'b1;
    end
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_q       <= TAB_RST;
      sbo_q       <= 1'b0;
      dfa_q       <= '0;
      line_q      <= 20'd1;
      col_q       <= '0;
      sline_q     <= 20'd1;
      scol_q      <= 16'd1;
      len_q       <= '0;
      ltc_q       <= '0;
      hv_q        <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      tcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      dfa_q       <= dfa_d;
      line_q      <= line_d;
      col_q       <= col_d;
      sline_q     <= sline_d;
      scol_q      <= scol_d;
      len_q       <= len_d;
      ltc_q       <= ltc_d;
      hv_q        <= hv_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      tcnt_q      <= tcnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TAB_WIDTH: tab_q <= cfg_data_i;
          CFG_SEVEN_BIT: sbo_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    eres_q     <= eres_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    ch_q       <= ch_d;
    term_q     <= term_d;
    oor_q      <= oor_d;
    st_oor_q   <= st_oor_d;
    tshift_q   <= tshift_d;
    rem_q      <= rem_d;
    tstep_q    <= tstep_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};
  assign m_axis_tlast  = out_last_q;

  a_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_acc |=> !s_axis_tready)
    else $error("ready after character transaction");

  a_dfa_eval_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EVAL) |=> $stable(dfa_q))
    else $error("DFA state changed outside evaluation");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TMOD && tcnt_q != 2'd0) |-> (rem_q < tw_eff))
    else $error("tab remainder out of range");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for table_driven_dfa_tokenizer: lexer table loads, character
// streams and tab/7-bit settings, each result compared against an in-bench token predictor.
// Depends on tdt_pkg and the tokenizer RTL.
module tb;
  import tdt_pkg::*;

  localparam int          IDLE_LIMIT   = 3000;
  localparam int          STALL_CYCLES = 400;
  localparam int          SETTLE       = 20;
  localparam logic [2:0]  CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0]  CMD_UNDEF_HI = 3'd7;
  localparam logic [12:0] VAL_WS       = 13'h1FFF;

  typedef struct packed {
    res_t tok;
    logic last;
  } tok_rec_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [3:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  table_driven_dfa_tokenizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [5:0]  cls_tbl [CLASS_DEPTH];
  logic [11:0] base_tbl[NUM_STATES];
  logic [7:0]  nxt_tbl [NEXT_TABLE_DEPTH];
  logic [10:0] term_tbl[NUM_STATES];
  logic [7:0]  dfa_st     = '0;
  logic [19:0] cur_line   = 20'd1;
  logic [15:0] cur_col    = '0;
  logic [19:0] tok_line   = 20'd1;
  logic [15:0] tok_col    = 16'd1;
  logic [15:0] tok_len    = '0;
  logic [15:0] line_toks  = '0;
  logic [3:0]  tab_cfg    = TAB_RST;
  logic        ascii_only = 1'b0;

  res_t     step_toks[$];
  tok_rec_t token_q[$];

  int          err_cnt      = 0;
  int          src_idle     = 0;
  int          dst_idle     = 0;
  int          quiet_cycles = 0;
  int unsigned stall_left   = 0;
  logic        stall_go     = 1'b0;
  logic        stall_ack    = 1'b0;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == COL_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] next_of(input logic [7:0] s, input logic [7:0] c);
    logic [7:0]  cc;
    logic [12:0] a;
    cc = (ascii_only && c[7]) ? 8'd0 : c;
    a  = {1'b0, base_tbl[s]} + 13'(cls_tbl[cc]);
    if (a >= NEXT_TABLE_DEPTH) return '0;
    return nxt_tbl[a[11:0]];
  endfunction

  task automatic start_token();
    tok_line = cur_line;
    tok_col  = bump16(cur_col);
    tok_len  = '0;
  endtask

  task automatic move_pos(input logic [7:0] c);
    int unsigned stop;
    int unsigned nc;
    if (c == CH_NL) begin
      if (cur_line != LINE_MAX) cur_line = cur_line + 20'd1;
      cur_col   = '0;
      line_toks = '0;
    end else if (c == CH_TAB) begin
      stop    = (tab_cfg == 0) ? 1 : tab_cfg;
      nc      = cur_col + (stop - (cur_col % stop));
      cur_col = (nc > COL_MAX) ? COL_MAX : nc[15:0];
    end else begin
      cur_col = bump16(cur_col);
    end
  endtask

  task automatic emit_token(input logic [10:0] t, input logic [15:0] n);
    res_t r;
    line_toks       = bump16(line_toks);
    r.terminal      = t[9:0];
    r.token_line    = tok_line;
    r.token_column  = tok_col;
    r.token_length  = n;
    r.token_on_line = line_toks;
    step_toks.push_back(r);
  endtask

  task automatic model_item(input logic [2:0] cmd, input logic [11:0] idx,
                            input logic [12:0] val, input logic [7:0] c);
    logic [7:0]  nx;
    logic [10:0] t;
    step_toks.delete();
    case (cmd)
      CMD_CLASS: if (idx < CLASS_DEPTH) cls_tbl[idx[7:0]] = val[5:0];
      CMD_BASE:  if (idx < NUM_STATES) base_tbl[idx[7:0]] = val[11:0];
      CMD_NEXT:  nxt_tbl[idx] = val[7:0];
      CMD_TERM:  if (idx < NUM_STATES) term_tbl[idx[7:0]] = val[10:0];
      CMD_CHAR: begin
        if (dfa_st == 0) start_token();
        nx = next_of(dfa_st, c);
        if (nx == 0 && dfa_st != 0) begin
          t = term_tbl[dfa_st];
          if (t != TERM_WS) emit_token(t, tok_len);
          dfa_st = '0;
          start_token();
          nx = next_of(8'd0, c);
        end
        if (nx != 0) begin
          move_pos(c);
          tok_len = bump16(tok_len);
          dfa_st  = nx;
        end else begin
          t = term_tbl[0];
          if (t == TERM_WS) t = '0;
          emit_token(t, 16'd1);
          move_pos(c);
          dfa_st = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < step_toks.size(); i++)
      token_q.push_back('{tok: step_toks[i], last: (i == step_toks.size() - 1)});
  endtask

  always @(posedge clk_i) begin
    tok_rec_t want;
    res_t     got;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      model_item(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[24:12], s_axis_tdata[32:25]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[77:0];
      if (token_q.size() == 0) begin
        $error("unexpected token transaction %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = token_q.pop_front();
        if (got.terminal != want.tok.terminal) begin
          $error("terminal: expected %0d, got %0d", want.tok.terminal, got.terminal);
          err_cnt++;
        end
        if (got.token_line != want.tok.token_line) begin
          $error("token_line: expected %0d, got %0d", want.tok.token_line, got.token_line);
          err_cnt++;
        end
        if (got.token_column != want.tok.token_column) begin
          $error("token_column: expected %0d, got %0d", want.tok.token_column,
                 got.token_column);
          err_cnt++;
        end
        if (got.token_length != want.tok.token_length) begin
          $error("token_length: expected %0d, got %0d", want.tok.token_length,
                 got.token_length);
          err_cnt++;
        end
        if (got.token_on_line != want.tok.token_on_line) begin
          $error("token_on_line: expected %0d, got %0d", want.tok.token_on_line,
                 got.token_on_line);
          err_cnt++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_go != stall_ack) begin
      stall_ack     <= stall_go;
      stall_left    <= STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [11:0] idx,
                           input logic [12:0] val, input logic [7:0] c);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, c, val, idx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(CMD_CHAR, 12'($urandom), 13'($urandom), c);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [3:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TAB_WIDTH) tab_cfg = data;
    else ascii_only = data[0];
    @(posedge clk_i);
  endtask

  function automatic logic [5:0] class_of(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return 6'd1;
    if (c >= "0" && c <= "9") return 6'd2;
    if (c == " " || c == CH_TAB || c == CH_NL || c == 8'h0D) return 6'd3;
    if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "<" || c == ">")
      return 6'd4;
    if (c == "#") return 6'd5;
    if (c == 8'h22) return 6'd6;
    if (c == ".") return 6'd7;
    if (c[7]) return {3'd0, c[2:0]};
    return 6'd0;
  endfunction

  // 0 reject, 1 ident, 2 number, 3 blank, 4 operator, 5 comment, 6/7 string, '.' joins numbers
  function automatic logic [7:0] dfa_init(input int s, input int k);
    case (s)
      0:       return 8'(k);
      1:       return (k == 1 || k == 2) ? 8'd1 : 8'd0;
      2:       return (k == 2 || k == 7) ? 8'd2 : 8'd0;
      3:       return (k == 3) ? 8'd3 : 8'd0;
      6:       return (k == 6) ? 8'd7 : 8'd6;
      7:       return (k == 2) ? 8'd2 : 8'd0;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
    if (r < 38) return "_";
    if (r < 50) return "0" + 8'($urandom_range(9));
    if (r < 62) return " ";
    if (r < 67) return CH_TAB;
    if (r < 72) return CH_NL;
    if (r < 80) return ($urandom_range(1) ? "+" : "=");
    if (r < 84) return "#";
    if (r < 88) return 8'h22;
    if (r < 91) return ".";
    if (r < 95) return 8'($urandom_range(126, 32));
    return 8'($urandom_range(255));
  endfunction

  // keep every reachable lookup on written entries: classes 0..7, states 0..7,
  // row bases 0..56 or 4088..4095
  task automatic load_tables();
    for (int c = 0; c < CLASS_DEPTH; c++)
      send_item(CMD_CLASS, 12'(c), {7'($urandom), class_of(8'(c))}, 8'($urandom));
    for (int s = 0; s < 8; s++) begin
      send_item(CMD_BASE, 12'(s), (s == 5) ? 13'hFFF : 13'(s * 8), 8'($urandom));
      send_item(CMD_TERM, 12'(s), (s == 3) ? VAL_WS : ((s == 0) ? 13'd9 : 13'(s)),
                8'($urandom));
      for (int k = 0; k < 8; k++)
        send_item(CMD_NEXT, 12'(s * 8 + k), {5'($urandom), dfa_init(s, k)}, 8'($urandom));
    end
    for (int i = 4088; i < 4095; i++)
      send_item(CMD_NEXT, 12'(i), {5'($urandom), 8'($urandom_range(7))}, 8'($urandom));
    send_item(CMD_NEXT, 12'd4095, 13'd5, 8'($urandom));
    send_item(CMD_CLASS, 12'($urandom_range(4095, 256)), 13'($urandom), 8'($urandom));
    send_item(CMD_BASE, 12'($urandom_range(4095, 256)), 13'($urandom), 8'($urandom));
    send_item(CMD_TERM, 12'($urandom_range(4095, 256)), 13'($urandom), 8'($urandom));
  endtask

  task automatic send_table_write();
    logic [11:0] idx;
    logic [12:0] v;
    v = 13'($urandom);
    case ($urandom_range(3))
      0: begin
        idx = $urandom_range(1) ? 12'($urandom_range(255)) : 12'($urandom_range(4095, 256));
        v[5:3] = '0;
        send_item(CMD_CLASS, idx, v, 8'($urandom));
      end
      1: begin
        if ($urandom_range(1)) begin
          idx = 12'($urandom_range(7));
          v[11:0] = $urandom_range(1) ? 12'($urandom_range(56)) : 12'($urandom_range(4095, 4088));
        end else begin
          idx = 12'($urandom_range(4095, 8));
        end
        send_item(CMD_BASE, idx, v, 8'($urandom));
      end
      2: begin
        if ($urandom_range(1)) begin
          idx = $urandom_range(1) ? 12'($urandom_range(63)) : 12'($urandom_range(4095, 4088));
          v[7:0] = 8'($urandom_range(7));
        end else begin
          idx = 12'($urandom_range(4087, 64));
        end
        send_item(CMD_NEXT, idx, v, 8'($urandom));
      end
      default: begin
        if ($urandom_range(3) == 0) v = VAL_WS;
        send_item(CMD_TERM, 12'($urandom), v, 8'($urandom));
      end
    endcase
  endtask

  task automatic test_directed();
    logic [7:0] txt[$];
    txt = '{"a", "b", "9", "~", " ", CH_TAB, "1", "2", ".", "5", CH_NL, "#", "x",
            8'hFF, 8'h80, 8'h00, "+", "+"};
    foreach (txt[i]) send_char(txt[i]);
    send_item(CMD_TERM, 12'd0, VAL_WS, 8'($urandom));
    send_char("~");
    send_item(CMD_TERM, 12'd0, 13'h13FE, 8'($urandom));
    send_char("~");
    send_item(CMD_TERM, 12'd0, 13'd9, 8'($urandom));
    for (int c = CMD_UNDEF_LO; c <= CMD_UNDEF_HI; c++)
      send_item(3'(c), 12'($urandom), 13'($urandom), 8'($urandom));
    wait_idle();
  endtask

  task automatic test_tab_and_ascii_modes();
    logic [3:0] widths[5];
    widths = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(14, 2)), TAB_RST};
    for (int i = 0; i < 5; i++) begin
      wait_idle();
      cfg_write(CFG_TAB_WIDTH, widths[i]);
      cfg_write(CFG_SEVEN_BIT, {3'($urandom), ~i[0]});
      repeat (14) begin
        case ($urandom_range(2))
          0:       send_char(CH_TAB);
          1:       send_char(8'($urandom_range(255, 128)));
          default: send_char(pick_char());
        endcase
      end
    end
    wait_idle();
  endtask

  task automatic test_random_text(input int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_item(3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO)), 12'($urandom),
                  13'($urandom), 8'($urandom));
      end else begin
        if (r < 8) send_table_write();
        else send_char(pick_char());
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic test_output_stall();
    stall_go <= ~stall_go;
    repeat (40) send_char("+");
    send_char(CH_NL);
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_tables();
    src_idle = 13;
    dst_idle = 70;
    test_directed();
    test_tab_and_ascii_modes();
    test_random_text(80);
    src_idle = 70;
    dst_idle = 13;
    test_output_stall();
    test_random_text(80);
    src_idle = 0;
    dst_idle = 0;
    test_random_text(80);
    if (err_cnt == 0 && token_q.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tdt_pkg.sv
rtl/tdt_ram.sv
rtl/table_driven_dfa_tokenizer.sv
sim/tb.sv
